@@ rtl/tpfi_pkg.sv @@
// Types and constants shared by the two-point flow interpolation unit.
`timescale 1ns / 1ps
`default_nettype none
package tpfi_pkg;

	localparam int IN_W     = 16;
	localparam int SPAN_W   = 17;
	localparam int DFLOW_W  = 8;
	localparam int DVD_W    = 27;
	localparam int DVS_W    = 16;
	localparam int Q_W      = 28;
	localparam int PROD_W   = 45;
	localparam int PMAG_W   = 43;
	localparam int DIV_SH   = 5;
	localparam int Y_W      = 38;
	localparam int HALF_W   = 19;
	localparam int MLO_W    = 20;
	localparam int RECIP_W  = 39;
	localparam int PP_W     = 39;
	localparam int MID_W    = 40;
	localparam int PR_W     = 77;
	localparam int RECIP_SH = 50;

	localparam int signed DFLOW_MIN   = -100;
	localparam int signed DFLOW_MAX   = 100;
	localparam int unsigned SCALE_UP    = 1000000;
	localparam int unsigned SCALE_DOWN  = 100000;
	localparam int unsigned FLOW_TENTHS = 10;

	// ceil(2^50 / 3125); 100000 = 32 * 3125
	localparam logic [RECIP_W-1:0]       RECIP_M  = 39'd360287970190;
	localparam logic [MLO_W-1:0]         RECIP_LO = RECIP_M[MLO_W-1:0];
	localparam logic [RECIP_W-MLO_W-1:0] RECIP_HI = RECIP_M[RECIP_W-1:MLO_W];

	typedef struct packed {
		logic signed [IN_W-1:0] raw_reading;
		logic signed [IN_W-1:0] reading_upper;
		logic signed [IN_W-1:0] reading_lower;
		logic [IN_W-1:0]        flow_upper;
		logic [IN_W-1:0]        flow_lower;
	} req_t;

	typedef struct packed {
		logic signed [IN_W-1:0] flow_value;
		logic                   zero_span;
	} res_t;

	typedef struct packed {
		logic                     neg;
		logic signed [SPAN_W-1:0] diff;
		logic [IN_W-1:0]          flo;
		logic                     zero;
	} div1_side_t;

	typedef struct packed {
		logic            neg;
		logic [IN_W-1:0] flo;
		logic            zero;
	} div2_side_t;

endpackage
`default_nettype wire

@@ rtl/tpfi_div_cell.sv @@
// One restoring-division cell: produces one quotient bit per item.
`timescale 1ns / 1ps
`default_nettype none
module tpfi_div_cell #(
	parameter int RW = 16,
	parameter int NW = 27,
	parameter type side_t = logic
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid_in,
	input  logic [RW+NW-1:0] acc_in,
	input  logic [RW-1:0]  div_in,
	input  side_t          side_in,
	output logic           valid_out,
	output logic [RW+NW-1:0] acc_out,
	output logic [RW-1:0]  div_out,
	output side_t          side_out
);
	localparam int AW = RW + NW;

	logic [AW:0]   sh;
	logic [RW:0]   top;
	logic [RW:0]   diff;
	logic [RW:0]   sel;
	logic          take;
	logic [AW-1:0] acc_nx;
	logic          valid_q;
	logic [AW-1:0] acc_q;
	logic [RW-1:0] div_q;
	side_t         side_q;

	always_comb begin
		sh     = {acc_in, 1'b0};
		top    = sh[AW:NW];
		diff   = top - {1'b0, div_in};
		take   = top >= {1'b0, div_in};
		sel    = take ? diff : top;
		acc_nx = {sel[RW-1:0], sh[NW-1:0]};
		acc_nx[0] = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q  <= acc_nx;
			div_q  <= div_in;
			side_q <= side_in;
		end
	end

	assign valid_out = valid_q;
	assign acc_out   = acc_q;
	assign div_out   = div_q;
	assign side_out  = side_q;
endmodule
`default_nettype wire

@@ rtl/tpfi_div_chain.sv @@
// Row of division cells: one quotient bit per cell, one item per cycle while en is high.
`timescale 1ns / 1ps
`default_nettype none
module tpfi_div_chain #(
	parameter int RW = 16,
	parameter int NW = 27,
	parameter type side_t = logic
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid_in,
	input  logic [RW+NW-1:0] acc_in,
	input  logic [RW-1:0]  div_in,
	input  side_t          side_in,
	output logic           valid_out,
	output logic [RW+NW-1:0] acc_out,
	output side_t          side_out
);
	logic [NW:0]      v;
	logic [RW+NW-1:0] acc  [NW+1];
	logic [RW-1:0]    dvs  [NW+1];
	side_t            side [NW+1];

	assign v[0]    = valid_in;
	assign acc[0]  = acc_in;
	assign dvs[0]  = div_in;
	assign side[0] = side_in;

	for (genvar k = 0; k < NW; k++) begin : g_cell
		tpfi_div_cell #(
			.RW(RW),
			.NW(NW),
			.side_t(side_t)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.valid_in(v[k]),
			.acc_in(acc[k]),
			.div_in(dvs[k]),
			.side_in(side[k]),
			.valid_out(v[k+1]),
			.acc_out(acc[k+1]),
			.div_out(dvs[k+1]),
			.side_out(side[k+1])
		);
	end

	assign valid_out = v[NW];
	assign acc_out   = acc[NW];
	assign side_out  = side[NW];
endmodule
`default_nettype wire

@@ rtl/two_point_flow_interpolation_unit.sv @@
// Two-point flow interpolation unit: top level with front stages and output skid.
// Pipeline from request acceptance to result valid: two setup stages,
// a 27-cell division chain, three multiply stages, three reciprocal scaling stages,
// output register.
// Throughput: one request per cycle while req_ready is high; the division cell row sets the depth.
// Reset: arst_n clears all valid flags; datapath registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module two_point_flow_interpolation_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  tpfi_pkg::req_t  req,
	output logic            res_valid,
	input  logic            res_ready,
	output tpfi_pkg::res_t  res
);
	import tpfi_pkg::*;

	logic en;

	logic signed [SPAN_W-1:0]  span_c;
	logic signed [SPAN_W-1:0]  df_c;
	logic signed [SPAN_W-1:0]  diff_c;
	logic signed [DFLOW_W-1:0] dflow_c;

	logic                      valid_s1;
	logic signed [SPAN_W-1:0]  span_s1;
	logic signed [DFLOW_W-1:0] dflow_s1;
	logic signed [SPAN_W-1:0]  diff_s1;
	logic [IN_W-1:0]           flo_s1;

	logic [DFLOW_W-1:0] dabs_c;
	logic [SPAN_W-1:0]  sabs_c;

	logic             valid_s2;
	logic [DVD_W-1:0] dvd_s2;
	logic [DVS_W-1:0] dvs_s2;
	div1_side_t       side_s2;

	logic                   d1_valid;
	logic [DVS_W+DVD_W-1:0] d1_acc;
	div1_side_t             d1_side;

	logic signed [Q_W-1:0] q_c;
	logic                  valid_s3;
	logic signed [Q_W-1:0] q_s3;
	div1_side_t            side_s3;

	logic                     valid_s4;
	logic signed [PROD_W-1:0] p_s4;
	div2_side_t               side_s4;

	logic [PROD_W-1:0] pabs_c;
	logic              valid_s5;
	logic [Y_W-1:0]    pmag_s5;
	div2_side_t        side_s5;

	logic             valid_s6;
	logic [PP_W-1:0]  pp_ll_s6;
	logic [PP_W-1:0]  pp_lh_s6;
	logic [PP_W-1:0]  pp_hl_s6;
	logic [PP_W-1:0]  pp_hh_s6;
	div2_side_t       side_s6;

	logic             valid_s7;
	logic [MID_W-1:0] mid_s7;
	logic [PP_W-1:0]  pp_ll_s7;
	logic [PP_W-1:0]  pp_hh_s7;
	div2_side_t       side_s7;

	logic [PR_W-1:0] prod_c;

	logic            valid_s8;
	logic [IN_W-1:0] tmag_s8;
	div2_side_t      side_s8;

	logic [IN_W-1:0] t_c;
	logic [IN_W-1:0] f10_c;
	res_t            tail_c;

	logic res_valid_q;
	res_t res_q;
	logic skid_valid_q;
	res_t skid_q;

	assign en        = !skid_valid_q;
	assign req_ready = en;

	always_comb begin
		span_c = {req.reading_upper[IN_W-1], req.reading_upper}
			- {req.reading_lower[IN_W-1], req.reading_lower};
		diff_c = {req.raw_reading[IN_W-1], req.raw_reading}
			- {req.reading_lower[IN_W-1], req.reading_lower};
		df_c = {1'b0, req.flow_upper} - {1'b0, req.flow_lower};
		if (df_c < DFLOW_MIN) begin
			dflow_c = DFLOW_W'(DFLOW_MIN);
		end else if (df_c > DFLOW_MAX) begin
			dflow_c = DFLOW_W'(DFLOW_MAX);
		end else begin
			dflow_c = df_c[DFLOW_W-1:0];
		end
	end

	always_comb begin
		dabs_c = dflow_s1[DFLOW_W-1] ? DFLOW_W'(-dflow_s1) : dflow_s1;
		sabs_c = span_s1[SPAN_W-1] ? SPAN_W'(-span_s1) : span_s1;
	end

	assign q_c    = {1'b0, d1_acc[DVD_W-1:0]};
	assign pabs_c = p_s4[PROD_W-1] ? PROD_W'(-p_s4) : p_s4;
	assign prod_c = {pp_hh_s7[PR_W-HALF_W-MLO_W-1:0], {(HALF_W+MLO_W){1'b0}}}
		+ PR_W'({mid_s7, {HALF_W{1'b0}}}) + PR_W'(pp_ll_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= d1_valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			span_s1  <= span_c;
			dflow_s1 <= dflow_c;
			diff_s1  <= diff_c;
			flo_s1   <= req.flow_lower;

			dvd_s2       <= DVD_W'(dabs_c[DFLOW_W-2:0] * SCALE_UP);
			dvs_s2       <= sabs_c[DVS_W-1:0];
			side_s2.neg  <= dflow_s1[DFLOW_W-1] ^ span_s1[SPAN_W-1];
			side_s2.diff <= diff_s1;
			side_s2.flo  <= flo_s1;
			side_s2.zero <= span_s1 == '0;

			q_s3    <= d1_side.neg ? -q_c : q_c;
			side_s3 <= d1_side;

			p_s4         <= q_s3 * side_s3.diff;
			side_s4.neg  <= 1'b0;
			side_s4.flo  <= side_s3.flo;
			side_s4.zero <= side_s3.zero;

			pmag_s5      <= pabs_c[PMAG_W-1:DIV_SH];
			side_s5.neg  <= p_s4[PROD_W-1];
			side_s5.flo  <= side_s4.flo;
			side_s5.zero <= side_s4.zero;

			pp_ll_s6 <= PP_W'(pmag_s5[HALF_W-1:0]) * PP_W'(RECIP_LO);
			pp_lh_s6 <= PP_W'(pmag_s5[HALF_W-1:0]) * PP_W'(RECIP_HI);
			pp_hl_s6 <= PP_W'(pmag_s5[Y_W-1:HALF_W]) * PP_W'(RECIP_LO);
			pp_hh_s6 <= PP_W'(pmag_s5[Y_W-1:HALF_W]) * PP_W'(RECIP_HI);
			side_s6  <= side_s5;

			mid_s7   <= {1'b0, pp_hl_s6} + {pp_lh_s6, 1'b0};
			pp_ll_s7 <= pp_ll_s6;
			pp_hh_s7 <= pp_hh_s6;
			side_s7  <= side_s6;

			tmag_s8 <= prod_c[RECIP_SH +: IN_W];
			side_s8 <= side_s7;
		end
	end

	tpfi_div_chain #(
		.RW(DVS_W),
		.NW(DVD_W),
		.side_t(div1_side_t)
	) u_div_q (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_in(valid_s2),
		.acc_in({DVS_W'(0), dvd_s2}),
		.div_in(dvs_s2),
		.side_in(side_s2),
		.valid_out(d1_valid),
		.acc_out(d1_acc),
		.side_out(d1_side)
	);

	always_comb begin
		t_c   = side_s8.neg ? IN_W'(-tmag_s8) : tmag_s8;
		f10_c = IN_W'(side_s8.flo * FLOW_TENTHS);
		tail_c.zero_span  = side_s8.zero;
		tail_c.flow_value = side_s8.zero ? '0 : f10_c + t_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (en && valid_s8) begin
			if (!res_valid_q || res_ready) begin
				res_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (res_valid_q && res_ready) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s8) begin
			if (!res_valid_q || res_ready) begin
				res_q <= tail_c;
			end else begin
				skid_q <= tail_c;
			end
		end else if (res_valid_q && res_ready && skid_valid_q) begin
			res_q <= skid_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q)
		else $error("skid holds a result while the output register is empty");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !res_ready |=> skid_valid_q && $stable(skid_q))
		else $error("skid result lost while output stalled");

	a_zero_span_flow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.zero_span |-> res.flow_value == '0)
		else $error("zero span result carries nonzero flow");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> $stable(valid_s5) && $stable(valid_s8))
		else $error("pipeline advanced while stalled");
`endif
endmodule
`default_nettype wire

@@ dv/tb_two_point_flow_interpolation_unit.sv @@
// Testbench for the two-point flow interpolation unit: random and directed requests checked against a local predictor.
`timescale 1ns / 1ps
module tb_two_point_flow_interpolation_unit;
	import tpfi_pkg::*;

	localparam int LATENCY        = 36;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_REPORTS    = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	res_t expected_flows[$];
	int   fail_count = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   hold_cycles = 0;
	int   quiet_cycles = 0;

	two_point_flow_interpolation_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic res_t interpolate_flow(req_t r);
		longint raw_v;
		longint rup_v;
		longint rlo_v;
		longint fup_v;
		longint flo_v;
		longint span;
		longint dflow;
		longint quot;
		longint trim;
		longint sum;
		res_t   o;
		raw_v = longint'($signed(r.raw_reading));
		rup_v = longint'($signed(r.reading_upper));
		rlo_v = longint'($signed(r.reading_lower));
		fup_v = longint'(r.flow_upper);
		flo_v = longint'(r.flow_lower);
		o = '0;
		span = rup_v - rlo_v;
		if (span == 0) begin
			o.zero_span = 1'b1;
			return o;
		end
		dflow = fup_v - flo_v;
		if (dflow < longint'(DFLOW_MIN)) dflow = longint'(DFLOW_MIN);
		if (dflow > longint'(DFLOW_MAX)) dflow = longint'(DFLOW_MAX);
		quot = (dflow * longint'(SCALE_UP)) / span;
		trim = (quot * (raw_v - rlo_v)) / longint'(SCALE_DOWN);
		sum = longint'(FLOW_TENTHS) * flo_v + trim;
		o.flow_value = sum[15:0];
		return o;
	endfunction

	function automatic req_t make_request(int raw, int rup, int rlo, int fup, int flo);
		req_t r;
		r.raw_reading   = raw[15:0];
		r.reading_upper = rup[15:0];
		r.reading_lower = rlo[15:0];
		r.flow_upper    = fup[15:0];
		r.flow_lower    = flo[15:0];
		return r;
	endfunction

	function automatic req_t random_request();
		int rlo;
		int rup;
		int raw;
		int flo;
		int fup;
		int span;
		logic [95:0] bits;
		req_t r;
		bits = {$urandom, $urandom, $urandom};
		r = bits[79:0];
		case ($urandom_range(0, 9))
			0: begin
				r.reading_upper = r.reading_lower;
			end
			1, 2: begin
			end
			3: begin
				rlo = int'($signed(r.reading_lower));
				rup = rlo + ($urandom_range(0, 1) ? int'($urandom_range(1, 4))
					: -int'($urandom_range(1, 4)));
				r.reading_upper = rup[15:0];
			end
			default: begin
				rlo  = int'($urandom_range(0, 20000)) - 20000;
				span = int'($urandom_range(100, 20000));
				raw  = rlo + int'($urandom_range(0, span + 10000)) - 5000;
				flo  = int'($urandom_range(0, 600));
				fup  = flo + int'($urandom_range(0, 300)) - 150;
				if (fup < 0) fup = 0;
				if ($urandom_range(0, 3) == 0) begin
					r = make_request(raw, rlo, rlo + span, fup, flo);
				end else begin
					r = make_request(raw, rlo + span, rlo, fup, flo);
				end
			end
		endcase
		return r;
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	task automatic send_request(req_t item);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		expected_flows.push_back(interpolate_flow(item));
	endtask

	task automatic send_random_batch(int count);
		repeat (count) send_request(random_request());
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_flows.size() != 0) @(posedge clk);
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	task automatic test_directed_cases();
		set_idling(10, 10);
		send_request(make_request(0, 0, 0, 0, 0));
		send_request(make_request(32767, -32768, -32768, 65535, 65535));
		send_request(make_request(-32768, 32767, 32767, 0, 0));
		send_request(make_request(100, 200, 0, 50, 20));
		send_request(make_request(32767, 32767, -32768, 65535, 0));
		send_request(make_request(-32768, 32767, -32768, 0, 65535));
		send_request(make_request(-32768, -32768, 32767, 100, 0));
		send_request(make_request(32767, 1, 0, 65535, 0));
		send_request(make_request(-32768, 0, 1, 0, 65535));
		send_request(make_request(5, 5, 4, 100, 200));
		send_request(make_request(0, 3, 0, 1, 0));
		send_request(make_request(-1, 3, 0, 1, 0));
		send_request(make_request(1234, 7, -3, 99, 0));
		send_request(make_request(0, 0, -7, 0, 100));
		send_request(make_request(-500, 1000, -500, 300, 200));
		send_request(make_request(0, 1000, 0, 0, 6553));
		send_request(make_request(0, 1000, 0, 0, 3276));
		send_request(make_request(-32768, 32767, 0, 101, 0));
		send_request(make_request(0, -1, 0, 0, 101));
		send_request(make_request(32767, -32768, 32767, 3, 65535));
		wait_drained();
	endtask

	task automatic test_receiver_stall_heavy();
		set_idling(15, 84);
		send_random_batch(600);
		wait_drained();
	endtask

	task automatic test_sender_gap_heavy();
		set_idling(84, 15);
		send_random_batch(600);
		wait_drained();
	endtask

	task automatic test_full_rate();
		set_idling(0, 0);
		send_random_batch(550);
		wait_drained();
	endtask

	task automatic test_backpressure_fill();
		set_idling(0, 0);
		hold_cycles = 300;
		send_random_batch(150);
		wait_drained();
	endtask

	task automatic test_drain_pause();
		set_idling(5, 5);
		send_random_batch(25);
		wait_drained();
		send_random_batch(25);
		wait_drained();
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			res_ready   <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_flows.size() == 0) begin
				note_failure($sformatf("unexpected result flow_value=%0d zero_span=%0b",
					res.flow_value, res.zero_span));
			end else begin
				want = expected_flows.pop_front();
				if (res.flow_value !== want.flow_value) begin
					note_failure($sformatf("flow_value mismatch: expected %0d, got %0d",
						want.flow_value, res.flow_value));
				end
				if (res.zero_span !== want.zero_span) begin
					note_failure($sformatf("zero_span mismatch: expected %0b, got %0b",
						want.zero_span, res.zero_span));
				end
			end
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (res_valid && res_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("tb_two_point_flow_interpolation_unit: FAIL");
		$finish;
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_receiver_stall_heavy();
		test_sender_gap_heavy();
		test_backpressure_fill();
		test_drain_pause();
		test_full_rate();
		repeat (2 * LATENCY) @(posedge clk);
		if (expected_flows.size() != 0) begin
			note_failure($sformatf("%0d results never arrived", expected_flows.size()));
		end
		if (fail_count == 0) begin
			$display("tb_two_point_flow_interpolation_unit: PASS");
		end else begin
			$display("tb_two_point_flow_interpolation_unit: FAIL");
		end
		$finish;
	end

endmodule
